[src/modexp_pkg.sv]
// Shared constants and types for the modular exponentiation unit.
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

    // Width of every operand and result port
    localparam int FIELD_W = 64;

    // Bit counter sized to hold any operand width up to FIELD_W
    localparam int BITCNT_W = $clog2(FIELD_W + 1);
    typedef logic [BITCNT_W-1:0] bitcnt_t;

endpackage

`default_nettype wire

[src/modular_exponentiation_unit.sv]
// Top level of the modular exponentiation unit (left-to-right square-and-multiply).
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Drive base_value, exponent_value and modulus_value and raise start. A word
//   is taken at a rising edge where start is high and busy is low; the low
//   WIDTH bits of each operand are used. busy stays high until the result.
//   The result is on power_residue and zero_modulus_error, marked by done,
//   which is high for exactly one cycle. The receiver cannot stall; busy drops
//   in the same cycle done is high, so a new word may be started there.
// Operation:
//   Zero modulus: done follows start in the next cycle, residue 0, error flag
//   set. Otherwise all modular products run on one shared shift-add multiplier
//   that does one modular add per cycle. An item needs one product to reduce
//   the base, WIDTH squarings and one multiplication per set exponent bit,
//   each product launched by a registered go strobe from the sequencer.
//   One item is processed at a time.
// Reset:
//   rst_n clears the sequencer and the done strobe; no item is in flight.

module modular_exponentiation_unit #(
    parameter int WIDTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [modexp_pkg::FIELD_W-1:0] base_value,
    input  logic [modexp_pkg::FIELD_W-1:0] exponent_value,
    input  logic [modexp_pkg::FIELD_W-1:0] modulus_value,
    output logic                          done,
    output logic [modexp_pkg::FIELD_W-1:0] power_residue,
    output logic                          zero_modulus_error
);
    import modexp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_SQUARE,
        S_MULT
    } state_t;

    state_t           state_reg;
    logic             done_reg;
    logic             err_reg;
    logic [WIDTH-1:0] result_reg;
    logic             mm_go_reg;
    logic [WIDTH-1:0] opa_reg;
    logic [WIDTH-1:0] opb_reg;
    logic [WIDTH-1:0] m_reg;
    logic [WIDTH-1:0] exp_reg;
    logic [WIDTH-1:0] base_red_reg;
    bitcnt_t          bit_cnt_reg;

    logic [WIDTH-1:0] base_in;
    logic [WIDTH-1:0] exp_in;
    logic [WIDTH-1:0] mod_in;
    logic [WIDTH-1:0] one_mod;
    logic             mm_done;
    logic [WIDTH-1:0] mm_product;
    logic             next_bit;
    logic             last_bit;

    // Starting accumulator: 1 mod m for the latched modulus
    function automatic logic [WIDTH-1:0] one_mod_acc(input logic [WIDTH-1:0] m);
        one_mod_acc = {{(WIDTH-1){1'b0}}, (m != WIDTH'(1))};
    endfunction

    // Keep only the low WIDTH bits of each operand
    assign base_in = base_value[WIDTH-1:0];
    assign exp_in  = exponent_value[WIDTH-1:0];
    assign mod_in  = modulus_value[WIDTH-1:0];

    // 1 mod m: zero when the modulus is one
    assign one_mod = {{(WIDTH-1){1'b0}}, (mod_in != WIDTH'(1))};

    // Shared modular multiplier
    modexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (mm_go_reg),
        .op_a    (opa_reg),
        .op_b    (opb_reg),
        .modulus (m_reg),
        .done    (mm_done),
        .product (mm_product)
    );

    // An exponent bit is finished after its square (bit clear) or its multiply
    assign next_bit = mm_done &&
                      (((state_reg == S_SQUARE) && !exp_reg[WIDTH-1]) ||
                       (state_reg == S_MULT));
    assign last_bit = (bit_cnt_reg == bitcnt_t'(1));

    // Sequencer: reduce base, then square and multiply per exponent bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            mm_go_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= 1'b0;
            mm_go_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (mod_in == '0)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            mm_go_reg <= 1'b1;
                            state_reg <= S_REDUCE;
                        end
                    end
                end
                S_REDUCE:
                begin
                    if (mm_done)
                    begin
                        mm_go_reg <= 1'b1;
                        state_reg <= S_SQUARE;
                    end
                end
                S_SQUARE:
                begin
                    if (mm_done && exp_reg[WIDTH-1])
                    begin
                        mm_go_reg <= 1'b1;
                        state_reg <= S_MULT;
                    end
                end
                S_MULT:
                begin
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Advance to the next exponent bit or finish
            if (next_bit)
            begin
                if (last_bit)
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                else
                begin
                    mm_go_reg <= 1'b1;
                    state_reg <= S_SQUARE;
                end
            end
        end
    end

    // Operand and result registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    m_reg       <= mod_in;
                    exp_reg     <= exp_in;
                    bit_cnt_reg <= bitcnt_t'(WIDTH);
                    opa_reg     <= one_mod;
                    opb_reg     <= base_in;
                    err_reg     <= (mod_in == '0);
                    result_reg  <= '0;
                end
            end
            S_REDUCE:
            begin
                if (mm_done)
                begin
                    base_red_reg <= mm_product;
                    opa_reg      <= one_mod_acc(m_reg);
                    opb_reg      <= one_mod_acc(m_reg);
                end
            end
            S_SQUARE:
            begin
                if (mm_done && exp_reg[WIDTH-1])
                begin
                    opa_reg <= mm_product;
                    opb_reg <= base_red_reg;
                end
            end
            S_MULT:
            begin
            end
            default:
            begin
            end
        endcase

        if (next_bit)
        begin
            exp_reg     <= {exp_reg[WIDTH-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg - bitcnt_t'(1);
            opa_reg     <= mm_product;
            opb_reg     <= mm_product;
            result_reg  <= mm_product;
        end
    end

    assign busy               = (state_reg != S_IDLE);
    assign done               = done_reg;
    assign power_residue      = FIELD_W'(result_reg);
    assign zero_modulus_error = err_reg;

`ifndef SYNTHESIS
    // A result never appears while an item is still in progress
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done raised while busy");

    // An accepted word leads to work or to an immediate result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted word dropped");

    // Error results carry a zero residue
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_modulus_error) |-> (power_residue == '0))
        else $error("nonzero residue on zero modulus");

    // A valid residue is always reduced below the modulus
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !zero_modulus_error) |-> (power_residue < FIELD_W'(m_reg)))
        else $error("residue not below modulus");
`endif

endmodule

`default_nettype wire

[src/modexp_mulmod.sv]
// Iterative modular multiplier: shift-add with one modular add per cycle.
`timescale 1ns / 1ps
`default_nettype none

module modexp_mulmod #(
    parameter int WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    input  logic [WIDTH-1:0] modulus,
    output logic             done,
    output logic [WIDTH-1:0] product
);
    import modexp_pkg::*;

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_DOUBLE,
        MM_ADD
    } mm_state_t;

    mm_state_t        state_reg;
    logic             done_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_shift_reg;
    bitcnt_t          cnt_reg;

    logic [WIDTH-1:0] addend;
    logic [WIDTH-1:0] gap;
    logic [WIDTH-1:0] acc_next;
    logic             bit_done;
    logic             last_bit;

    // Shared modular adder: acc + addend mod m, both operands below m
    always_comb
    begin
        addend   = (state_reg == MM_ADD) ? a_reg : acc_reg;
        gap      = modulus - addend;
        acc_next = (acc_reg >= gap) ? (acc_reg - gap) : (acc_reg + addend);
    end

    // A multiplier bit is finished after the double, or after the add when it is set
    assign bit_done = (state_reg == MM_ADD) ||
                      ((state_reg == MM_DOUBLE) && !b_shift_reg[WIDTH-1]);
    assign last_bit = (cnt_reg == bitcnt_t'(1));

    // Sequencer: double, conditionally add, advance to the next multiplier bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                MM_IDLE:
                begin
                    if (go)
                    begin
                        state_reg <= MM_DOUBLE;
                    end
                end
                MM_DOUBLE:
                begin
                    if (b_shift_reg[WIDTH-1])
                    begin
                        state_reg <= MM_ADD;
                    end
                    else if (last_bit)
                    begin
                        state_reg <= MM_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                MM_ADD:
                begin
                    if (last_bit)
                    begin
                        state_reg <= MM_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= MM_DOUBLE;
                    end
                end
                default:
                begin
                    state_reg <= MM_IDLE;
                end
            endcase
        end
    end

    // Datapath: load operands on go, update accumulator while running
    always_ff @(posedge clk)
    begin
        if (state_reg == MM_IDLE)
        begin
            if (go)
            begin
                acc_reg     <= '0;
                a_reg       <= op_a;
                b_shift_reg <= op_b;
                cnt_reg     <= bitcnt_t'(WIDTH);
            end
        end
        else
        begin
            acc_reg <= acc_next;
            if (bit_done)
            begin
                b_shift_reg <= {b_shift_reg[WIDTH-2:0], 1'b0};
                cnt_reg     <= cnt_reg - bitcnt_t'(1);
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire
